[rtl/iht_pkg.sv]
package iht_pkg;

  // Configuration register file
  localparam int unsigned CFG_ADDR_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam int unsigned GEOM_REG_BITS  = 11;
  localparam int unsigned THR_BITS       = 16;
  localparam int unsigned PASS_REG_BITS  = 4;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    REG_FRAME_WIDTH      = 3'd0,
    REG_FRAME_HEIGHT     = 3'd1,
    REG_STRONG_THRESHOLD = 3'd2,
    REG_WEAK_THRESHOLD   = 3'd3,
    REG_PASS_COUNT       = 3'd4,
    REG_EXT_CONTOUR_MODE = 3'd5
  } cfg_reg_e;

  localparam logic [GEOM_REG_BITS-1:0] RST_FRAME_WIDTH      = 11'd512;
  localparam logic [GEOM_REG_BITS-1:0] RST_FRAME_HEIGHT     = 11'd512;
  localparam logic [THR_BITS-1:0]      RST_STRONG_THRESHOLD = 16'd400;
  localparam logic [THR_BITS-1:0]      RST_WEAK_THRESHOLD   = 16'd80;
  localparam logic [PASS_REG_BITS-1:0] RST_PASS_COUNT       = 4'd1;
  localparam logic                     RST_EXT_CONTOUR_MODE = 1'b0;

  // Default sizing
  localparam int unsigned DEF_MAX_WIDTH      = 1024;
  localparam int unsigned DEF_MAX_HEIGHT     = 1024;
  localparam int unsigned DEF_MAX_PASSES     = 8;
  localparam int unsigned DEF_INTENSITY_BITS = 16;

  // Output pixel codes
  localparam logic [7:0] PIXEL_EDGE       = 8'd0;
  localparam logic [7:0] PIXEL_BACKGROUND = 8'd255;

  // Input command codes
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Control bundle that travels from cell to cell with every item slot.
  typedef struct packed {
    logic valid;      // slot carries an accepted item
    logic fired;      // the producing stage emitted a pixel for this item
    logic mark;       // contour bit of that pixel
    logic res_valid;  // the selected stage produced the result of this item
    logic res_mark;   // contour bit of the result
    logic res_fe;     // result is the last pixel of its frame
  } chain_ctl_t;

endpackage

[rtl/iht_ram.sv]
module iht_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

[rtl/iht_raster.sv]
module iht_raster #(
  parameter int unsigned MAX_WIDTH  = iht_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = iht_pkg::DEF_MAX_HEIGHT,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  logic [WW-1:0] width_i,
  input  logic [HW-1:0] height_i,
  output logic [RW-1:0] row_o,
  output logic [CW-1:0] col_o,
  output logic          frame_end_o
);

  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_inc;

  assign col_inc = WW'(col_q) + WW'(1);
  assign row_inc = HW'(row_q) + HW'(1);

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (col_inc >= width_i) begin
      col_d = '0;
      if (row_inc >= height_i) begin
        row_d = '0;
      end else begin
        row_d = row_inc[RW-1:0];
      end
    end else begin
      col_d = col_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (step_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign row_o       = row_q;
  assign col_o       = col_q;
  assign frame_end_o = (WW'(col_q) == width_i - WW'(1)) && (HW'(row_q) == height_i - HW'(1));

endmodule

[rtl/iht_source.sv]
module iht_source #(
  parameter int unsigned MAX_WIDTH      = iht_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT     = iht_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned INTENSITY_BITS = iht_pkg::DEF_INTENSITY_BITS,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned CMPW = (INTENSITY_BITS > iht_pkg::THR_BITS) ?
                                 INTENSITY_BITS : iht_pkg::THR_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             in_valid_i,
  input  logic                             cmd_i,
  input  logic [INTENSITY_BITS-1:0]        intensity_i,
  input  logic                             contour_i,
  input  logic [WW-1:0]                    width_i,
  input  logic [HW-1:0]                    height_i,
  input  logic [iht_pkg::THR_BITS-1:0]     strong_i,
  input  logic                             ext_mode_i,
  input  logic                             tap_zero_i,
  output iht_pkg::chain_ctl_t              ctl_o,
  output logic [INTENSITY_BITS-1:0]        intensity_o
);

  iht_pkg::chain_ctl_t           ctl_q;
  logic [INTENSITY_BITS-1:0]     inten_q;
  logic                          pixel;
  logic                          mark;
  logic                          frame_end;

  assign pixel = in_valid_i && (cmd_i == iht_pkg::CMD_PIXEL);
  assign mark  = ext_mode_i ? contour_i : (CMPW'(intensity_i) >= CMPW'(strong_i));

  iht_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (en_i && pixel),
    .width_i     (width_i),
    .height_i    (height_i),
    .row_o       (),
    .col_o       (),
    .frame_end_o (frame_end)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.valid     <= in_valid_i;
      ctl_q.fired     <= pixel;
      ctl_q.mark      <= mark;
      ctl_q.res_valid <= pixel && tap_zero_i;
      ctl_q.res_mark  <= mark;
      ctl_q.res_fe    <= frame_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inten_q <= intensity_i;
    end
  end

  assign ctl_o       = ctl_q;
  assign intensity_o = inten_q;

endmodule

[rtl/iht_cell.sv]
module iht_cell #(
  parameter int unsigned STAGE          = 1,
  parameter int unsigned MAX_WIDTH      = iht_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT     = iht_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_PASSES     = iht_pkg::DEF_MAX_PASSES,
  parameter int unsigned INTENSITY_BITS = iht_pkg::DEF_INTENSITY_BITS,
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1),
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1),
  localparam int unsigned TW = $clog2(MAX_PASSES + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  iht_pkg::chain_ctl_t          ctl_i,
  input  logic [INTENSITY_BITS-1:0]    intensity_i,
  input  logic [WW-1:0]                width_i,
  input  logic [HW-1:0]                height_i,
  input  logic [iht_pkg::THR_BITS-1:0] weak_i,
  input  logic [TW-1:0]                tap_i,
  output iht_pkg::chain_ctl_t          ctl_o,
  output logic [INTENSITY_BITS-1:0]    intensity_o
);

  localparam int unsigned CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned NW   = WW + 1;
  localparam int unsigned AW   = $clog2(2 * MAX_WIDTH + 4);
  localparam int unsigned RING = 2 ** AW;
  localparam int unsigned CMPW = (INTENSITY_BITS > iht_pkg::THR_BITS) ?
                                 INTENSITY_BITS : iht_pkg::THR_BITS;
  localparam logic [TW-1:0] MY_STAGE = TW'(STAGE);

  // Ring write side: the previous stage's pixels land here in order.
  logic [AW-1:0] wr_q;
  logic          wr_en;

  // Decision stage
  iht_pkg::chain_ctl_t a_ctl_q;
  logic [NW-1:0]       avail_q, avail_new, need;
  logic [AW-1:0]       rd_q;
  logic                fire;
  logic [RW-1:0]       row;
  logic [CW-1:0]       col;
  logic                frame_end;
  logic                frame_start;
  logic [NW-1:0]       w_ext, cw_ext;
  logic [HW-1:0]       hm1, r_ext;
  logic [AW-1:0]       addr_mid, addr_top, addr_bot;

  // Evaluation stage
  logic b_valid_q, b_fire_q, b_fe_q, b_first_q;
  logic b_up_q, b_dn_q, b_lf_q, b_rt_q;
  logic b_res_valid_q, b_res_mark_q, b_res_fe_q;
  logic [2:0] col_l_q, col_c_q;   // bit 2 row above, bit 1 own row, bit 0 row below
  logic [INTENSITY_BITS:0] ram_i_a, ram_i_b;
  logic                    ram_c_a, ram_c_b;
  logic [INTENSITY_BITS-1:0] inten_c;
  logic                    dn_bit;
  logic                    nb_hit, mark;

  iht_pkg::chain_ctl_t       ctl_q;
  logic [INTENSITY_BITS-1:0] inten_q;

  assign wr_en = en_i && ctl_i.valid && ctl_i.fired;

  // Contour bits of the rows above and below.
  iht_ram #(
    .WIDTH (1),
    .DEPTH (RING)
  ) u_ram_contour (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_q),
    .wdata_i   (ctl_i.mark),
    .re_i      (en_i),
    .raddr_a_i (addr_top),
    .raddr_b_i (addr_bot),
    .rdata_a_o (ram_c_a),
    .rdata_b_o (ram_c_b)
  );

  // Intensity with contour bit, read at the center and at its right neighbor.
  iht_ram #(
    .WIDTH (INTENSITY_BITS + 1),
    .DEPTH (RING)
  ) u_ram_pixel (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_q),
    .wdata_i   ({intensity_i, ctl_i.mark}),
    .re_i      (en_i),
    .raddr_a_i (addr_mid),
    .raddr_b_i (rd_q),
    .rdata_a_o (ram_i_a),
    .rdata_b_o (ram_i_b)
  );

  iht_raster #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_raster (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (en_i && fire),
    .width_i     (width_i),
    .height_i    (height_i),
    .row_o       (row),
    .col_o       (col),
    .frame_end_o (frame_end)
  );

  // How many pixels past the current one must exist before it can be judged.
  assign w_ext  = NW'(width_i);
  assign cw_ext = NW'(col);
  assign hm1    = height_i - HW'(1);
  assign r_ext  = HW'(row);

  always_comb begin
    if (r_ext > hm1) begin
      need = '0;
    end else if (r_ext == hm1) begin
      need = (cw_ext >= w_ext - NW'(1)) ? '0 : (w_ext - NW'(1) - cw_ext);
    end else if ((r_ext == hm1 - HW'(1)) && (cw_ext >= w_ext - NW'(1))) begin
      need = w_ext;
    end else begin
      need = w_ext + NW'(1);
    end
  end

  assign avail_new = avail_q + NW'(a_ctl_q.valid && a_ctl_q.fired);
  assign fire      = a_ctl_q.valid && (avail_new > need);

  // The first pixel of a frame has no row above, so the upper contour port
  // fetches the pixel below it instead.
  assign frame_start = (row == '0) && (col == '0);

  assign addr_mid = rd_q + AW'(1);
  assign addr_top = frame_start ? (rd_q + AW'(width_i)) : (addr_mid - AW'(width_i));
  assign addr_bot = addr_mid + AW'(width_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q     <= '0;
      a_ctl_q  <= '0;
      avail_q  <= '0;
      rd_q     <= '0;
    end else if (en_i) begin
      if (wr_en) begin
        wr_q <= wr_q + AW'(1);
      end
      a_ctl_q <= ctl_i;
      avail_q <= avail_new - NW'(fire);
      if (fire) begin
        rd_q <= rd_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q     <= 1'b0;
      b_fire_q      <= 1'b0;
      b_fe_q        <= 1'b0;
      b_first_q     <= 1'b0;
      b_up_q        <= 1'b0;
      b_dn_q        <= 1'b0;
      b_lf_q        <= 1'b0;
      b_rt_q        <= 1'b0;
      b_res_valid_q <= 1'b0;
      b_res_mark_q  <= 1'b0;
      b_res_fe_q    <= 1'b0;
    end else if (en_i) begin
      b_valid_q     <= a_ctl_q.valid;
      b_fire_q      <= fire;
      b_fe_q        <= frame_end;
      b_first_q     <= frame_start;
      b_up_q        <= r_ext != '0;
      b_dn_q        <= r_ext < hm1;
      b_lf_q        <= cw_ext != '0;
      b_rt_q        <= cw_ext < w_ext - NW'(1);
      b_res_valid_q <= a_ctl_q.res_valid;
      b_res_mark_q  <= a_ctl_q.res_mark;
      b_res_fe_q    <= a_ctl_q.res_fe;
    end
  end

  assign inten_c = ram_i_b[INTENSITY_BITS:1];
  assign dn_bit  = b_first_q ? ram_c_a : col_c_q[0];

  always_comb begin
    nb_hit = (b_up_q && col_c_q[2]) || (b_dn_q && dn_bit) ||
             (b_lf_q && col_l_q[1]) || (b_rt_q && ram_i_a[0]);
    if (b_up_q && b_dn_q && b_lf_q && b_rt_q) begin
      nb_hit = nb_hit || col_l_q[2] || col_l_q[0] || ram_c_a || ram_c_b;
    end
    mark = (CMPW'(inten_c) >= CMPW'(weak_i)) && nb_hit;
  end

  // The window slides by one column per pixel this stage handles. The column
  // of a frame's first pixel is read fresh at that pixel, since the read made
  // at the previous frame's last pixel may predate those pixels. Its own bit
  // also serves as the row above for a one-column frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_l_q <= '0;
      col_c_q <= '0;
    end else if (en_i) begin
      if (b_fire_q) begin
        if (b_first_q) begin
          col_l_q <= {1'b0, ram_i_b[0], ram_c_a};
          col_c_q <= {ram_i_b[0], ram_i_a[0], ram_c_b};
        end else begin
          col_l_q <= col_c_q;
          col_c_q <= {ram_c_a, ram_i_a[0], ram_c_b};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q.valid <= b_valid_q;
      ctl_q.fired <= b_fire_q;
      ctl_q.mark  <= mark;
      if (b_fire_q && (tap_i == MY_STAGE)) begin
        ctl_q.res_valid <= 1'b1;
        ctl_q.res_mark  <= mark;
        ctl_q.res_fe    <= b_fe_q;
      end else begin
        ctl_q.res_valid <= b_res_valid_q;
        ctl_q.res_mark  <= b_res_mark_q;
        ctl_q.res_fe    <= b_res_fe_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inten_q <= inten_c;
    end
  end

  assign ctl_o       = ctl_q;
  assign intensity_o = inten_q;

endmodule

[rtl/iterative_hysteresis_threshold_core.sv]
// An accepted item passes the source stage and every cell to the output register.
// Throughput: one item per cycle unless stalled; every cell advances once per cycle.
// The whole chain stalls only while a finished result waits in the output register.
// Reset clears the control registers, counters, ring pointers and windows at once; the ring
//   memories are not cleared and need no clearing pass.
module iterative_hysteresis_threshold_core #(
  parameter int unsigned MAX_WIDTH      = iht_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT     = iht_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_PASSES     = iht_pkg::DEF_MAX_PASSES,
  parameter int unsigned INTENSITY_BITS = iht_pkg::DEF_INTENSITY_BITS,
  localparam int unsigned IN_BYTES = (INTENSITY_BITS + 1 + 7) / 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [8*IN_BYTES-1:0]             s_axis_tdata,  // intensity, contour_in, zero fill
  input  logic                              s_axis_tuser,  // cmd
  // Result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // pixel_value
  output logic                              m_axis_tlast,  // frame_end
  // Configuration writes
  input  logic                              cfg_we_i,
  input  logic [iht_pkg::CFG_ADDR_BITS-1:0] cfg_addr_i,
  input  logic [iht_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned TW = $clog2(MAX_PASSES + 1);

  // Configuration registers.
  logic [iht_pkg::GEOM_REG_BITS-1:0] frame_width_q, frame_height_q;
  logic [iht_pkg::THR_BITS-1:0]      strong_q, weak_q;
  logic [iht_pkg::PASS_REG_BITS-1:0] pass_count_q;
  logic                              ext_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= iht_pkg::RST_FRAME_WIDTH;
      frame_height_q <= iht_pkg::RST_FRAME_HEIGHT;
      strong_q       <= iht_pkg::RST_STRONG_THRESHOLD;
      weak_q         <= iht_pkg::RST_WEAK_THRESHOLD;
      pass_count_q   <= iht_pkg::RST_PASS_COUNT;
      ext_mode_q     <= iht_pkg::RST_EXT_CONTOUR_MODE;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        iht_pkg::REG_FRAME_WIDTH:      frame_width_q  <= cfg_wdata_i[iht_pkg::GEOM_REG_BITS-1:0];
        iht_pkg::REG_FRAME_HEIGHT:     frame_height_q <= cfg_wdata_i[iht_pkg::GEOM_REG_BITS-1:0];
        iht_pkg::REG_STRONG_THRESHOLD: strong_q       <= cfg_wdata_i;
        iht_pkg::REG_WEAK_THRESHOLD:   weak_q         <= cfg_wdata_i;
        iht_pkg::REG_PASS_COUNT:       pass_count_q   <= cfg_wdata_i[iht_pkg::PASS_REG_BITS-1:0];
        iht_pkg::REG_EXT_CONTOUR_MODE: ext_mode_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Geometry is clamped to 1..MAX; a pass count beyond the chain selects its last cell.
  logic [WW-1:0] width_sat;
  logic [HW-1:0] height_sat;
  logic [TW-1:0] tap;

  always_comb begin
    if (frame_width_q == '0) begin
      width_sat = WW'(1);
    end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
      width_sat = WW'(MAX_WIDTH);
    end else begin
      width_sat = WW'(frame_width_q);
    end
    if (frame_height_q == '0) begin
      height_sat = HW'(1);
    end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
      height_sat = HW'(MAX_HEIGHT);
    end else begin
      height_sat = HW'(frame_height_q);
    end
    if (32'(pass_count_q) > 32'(MAX_PASSES)) begin
      tap = TW'(MAX_PASSES);
    end else begin
      tap = TW'(pass_count_q);
    end
  end

  // The chain moves whenever the output register is free or being emptied.
  logic en;
  logic out_valid_q;
  logic out_mark_q, out_fe_q;

  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // Chain of cells: the seed stage, then one growth cell per pass. Each link
  // carries one item slot per cycle while the chain moves, with the pixel the
  // stage emitted for it (if any) and the result once the selected stage has made it.
  iht_pkg::chain_ctl_t       ctl_chain   [MAX_PASSES + 1];
  logic [INTENSITY_BITS-1:0] inten_chain [MAX_PASSES + 1];

  iht_source #(
    .MAX_WIDTH      (MAX_WIDTH),
    .MAX_HEIGHT     (MAX_HEIGHT),
    .INTENSITY_BITS (INTENSITY_BITS)
  ) u_source (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (s_axis_tvalid),
    .cmd_i       (s_axis_tuser),
    .intensity_i (s_axis_tdata[INTENSITY_BITS-1:0]),
    .contour_i   (s_axis_tdata[INTENSITY_BITS]),
    .width_i     (width_sat),
    .height_i    (height_sat),
    .strong_i    (strong_q),
    .ext_mode_i  (ext_mode_q),
    .tap_zero_i  (tap == '0),
    .ctl_o       (ctl_chain[0]),
    .intensity_o (inten_chain[0])
  );

  for (genvar k = 1; k <= MAX_PASSES; k++) begin : g_cell
    iht_cell #(
      .STAGE          (k),
      .MAX_WIDTH      (MAX_WIDTH),
      .MAX_HEIGHT     (MAX_HEIGHT),
      .MAX_PASSES     (MAX_PASSES),
      .INTENSITY_BITS (INTENSITY_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .ctl_i       (ctl_chain[k-1]),
      .intensity_i (inten_chain[k-1]),
      .width_i     (width_sat),
      .height_i    (height_sat),
      .weak_i      (weak_q),
      .tap_i       (tap),
      .ctl_o       (ctl_chain[k]),
      .intensity_o (inten_chain[k])
    );
  end

  // Output register: an item slot that leaves the chain with a result loads it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= ctl_chain[MAX_PASSES].valid && ctl_chain[MAX_PASSES].res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_mark_q <= ctl_chain[MAX_PASSES].res_mark;
      out_fe_q   <= ctl_chain[MAX_PASSES].res_fe;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_mark_q ? iht_pkg::PIXEL_EDGE : iht_pkg::PIXEL_BACKGROUND;
  assign m_axis_tlast  = out_fe_q;

endmodule
